[rtl/ulrb_pkg.sv]
`default_nettype none

package ulrb_pkg;

   // Default geometry of the line store
   localparam int SlotsDef   = 4;
   localparam int LineLenDef = 256;

   // Fixed field widths on the ports
   localparam int CmdW    = 2;
   localparam int ByteW   = 8;
   localparam int RSlotW  = 2;
   localparam int ROffW   = 8;
   localparam int LSlotW  = 2;
   localparam int CountW  = 8;
   localparam int ReqDataW = 24;
   localparam int RspDataW = 24;

   // Byte that closes a line
   localparam logic [ByteW-1:0] NEWLINE = 8'd10;

   // Saturation value of the pending line count
   localparam logic [CountW-1:0] COUNT_MAX = 8'hFF;

   // Command codes carried in tuser
   typedef enum logic [CmdW-1:0] {
      CMD_PUSH = 2'd0,
      CMD_GET  = 2'd1,
      CMD_DONE = 2'd2,
      CMD_READ = 2'd3
   } cmd_type;

endpackage

`default_nettype wire

[rtl/ulrb_store.sv]
`default_nettype none

// Byte store for the line slots: one write port, one read port,
// read data registered.
module ulrb_store
   import ulrb_pkg::*;
#(
   parameter int DEPTH  = SlotsDef * LineLenDef,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [ByteW-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [ByteW-1:0]  rd_data
);

   logic [ByteW-1:0] mem [DEPTH];
   logic [ByteW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/uart_line_ring_buffer.sv]
`default_nettype none

// Line-buffered receive FIFO.
// Commands arrive on the req_ stream, one word each; the command code rides in
// req_tuser (0 push byte, 1 get next line, 2 line processed, 3 read byte).
// Every accepted word yields exactly one rsp_ word carrying line_ready,
// line_slot, the sticky overflow flag, read_data and the pending line count.
// Pushed bytes go into a ring of SLOTS slots of LINE_LEN bytes; a newline is
// stored, then closes the slot and bumps the pending count.
// A word accepted into the access stage sits there while the store read
// completes, then loads the output register and shows on rsp_ from then on.
// Throughput: one word per cycle while the output register is not stalled;
// all pointer updates finish in the accept cycle and the store has at most one
// access per command, so words can follow back to back.
// When rsp_tready is low the output register holds its word and one further
// word may still be taken into the access stage; after that req_tready drops.
// Reset (synchronous, active high) clears the pointers, the count, the
// overflow flag and both stage valids. The byte store is not cleared; a read
// of a never-written byte returns an arbitrary value.
module uart_line_ring_buffer
   import ulrb_pkg::*;
#(
   parameter int SLOTS    = SlotsDef,
   parameter int LINE_LEN = LineLenDef
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // rx_byte [7:0], read_slot [9:8], read_offset [17:10], zero [23:18]
   input  wire logic [ReqDataW-1:0] req_tdata,
   // command [1:0]
   input  wire logic [CmdW-1:0]     req_tuser,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // line_ready [0], line_slot [2:1], overflow [3], read_data [11:4],
   // pending_lines [19:12], zero [23:20]
   output logic [RspDataW-1:0]      rsp_tdata
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int OFF_W  = $clog2(LINE_LEN);
   localparam int DEPTH  = SLOTS * LINE_LEN;
   localparam int ADDR_W = $clog2(DEPTH);

   // input fields
   cmd_type           cmd;
   logic [ByteW-1:0]  rx_byte;
   logic [RSlotW-1:0] read_slot;
   logic [ROffW-1:0]  read_offset;

   assign cmd         = cmd_type'(req_tuser);
   assign rx_byte     = req_tdata[ByteW-1:0];
   assign read_slot   = req_tdata[ByteW+RSlotW-1:ByteW];
   assign read_offset = req_tdata[ByteW+RSlotW+ROffW-1:ByteW+RSlotW];

   // pointer and status state
   logic [SLOT_W-1:0] wslot_ff, wslot_in;
   logic [OFF_W-1:0]  woff_ff, woff_in;
   logic [SLOT_W-1:0] fslot_ff, fslot_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              ovf_ff, ovf_in;

   // access stage
   logic              s1_valid_ff;
   logic              s1_ready_ff, s1_ready_in;
   logic [LSlotW-1:0] s1_slot_ff, s1_slot_in;
   logic              s1_hit_ff, s1_hit_in;
   logic              s1_ovf_ff;
   logic [CountW-1:0] s1_count_ff;

   // output register
   logic              out_valid_ff;
   logic              out_ready_ff;
   logic [LSlotW-1:0] out_slot_ff;
   logic              out_ovf_ff;
   logic [ByteW-1:0]  out_data_ff;
   logic [CountW-1:0] out_count_ff;

   // store ports
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [ByteW-1:0]  mem_rdata;

   logic req_acc, s1_move;

   // handshake
   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_acc    = req_tvalid && req_tready;

   // store addresses
   assign mem_waddr = ADDR_W'(wslot_ff) * ADDR_W'(LINE_LEN) + ADDR_W'(woff_ff);
   assign mem_raddr = ADDR_W'(read_slot) * ADDR_W'(LINE_LEN) + ADDR_W'(read_offset);

   // command decode and state update
   always_comb begin
      wslot_in    = wslot_ff;
      woff_in     = woff_ff;
      fslot_in    = fslot_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      s1_ready_in = 1'b0;
      s1_slot_in  = '0;
      s1_hit_in   = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      if (req_acc) begin
         case (cmd)
            CMD_PUSH: begin
               mem_we = 1'b1;
               if (rx_byte == NEWLINE) begin
                  wslot_in = (wslot_ff == SLOT_W'(SLOTS - 1)) ? '0 : wslot_ff + 1'b1;
                  woff_in  = '0;
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
               end else if (woff_ff != OFF_W'(LINE_LEN - 1)) begin
                  woff_in = woff_ff + 1'b1;
               end
               if (count_in > CountW'(SLOTS)) begin
                  ovf_in = 1'b1;
               end
            end
            CMD_GET: begin
               if (count_ff != '0) begin
                  s1_ready_in = 1'b1;
                  s1_slot_in  = LSlotW'(fslot_ff);
                  fslot_in    = (fslot_ff == SLOT_W'(SLOTS - 1)) ? '0 : fslot_ff + 1'b1;
               end
            end
            CMD_DONE: begin
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
            end
            CMD_READ: begin
               if ((32'(read_slot) < SLOTS) && (32'(read_offset) < LINE_LEN)) begin
                  s1_hit_in = 1'b1;
                  mem_re    = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // pointer and status registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wslot_ff <= '0;
         woff_ff  <= '0;
         fslot_ff <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         wslot_ff <= wslot_in;
         woff_ff  <= woff_in;
         fslot_ff <= fslot_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // access stage: control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   // access stage: payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ready_ff <= s1_ready_in;
         s1_slot_ff  <= s1_slot_in;
         s1_hit_ff   <= s1_hit_in;
         s1_ovf_ff   <= ovf_in;
         s1_count_ff <= count_in;
      end
   end

   // output register: control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   // output register: payload, read data taken from the store here
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_ready_ff <= s1_ready_ff;
         out_slot_ff  <= s1_slot_ff;
         out_ovf_ff   <= s1_ovf_ff;
         out_data_ff  <= s1_hit_ff ? mem_rdata : '0;
         out_count_ff <= s1_count_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_count_ff, out_data_ff, out_ovf_ff, out_slot_ff, out_ready_ff};

   ulrb_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (rx_byte),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

`ifndef SYNTHESIS
   // overflow is sticky until reset
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag cleared without reset");

   // count only moves on an accepted word
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !req_acc |=> $stable(count_ff))
      else $error("pending count changed with no command");

   // write offset never passes the line end
   a_woff_range: assert property (@(posedge clock) disable iff (reset)
      32'(woff_ff) < LINE_LEN)
      else $error("write offset out of range");

   // a stalled access stage keeps its word
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_count_ff))
      else $error("access stage lost a word under stall");

   // a store read only starts when the stage can take it
   a_read_gate: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> req_acc && cmd == CMD_READ)
      else $error("store read without a read command");
`endif

endmodule

`default_nettype wire

[verif/tb_uart_line_ring_buffer.sv]
`timescale 1ns / 1ps

module tb_uart_line_ring_buffer;
   import ulrb_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int HoldOffCycles = 60;
   localparam int DrainCycles   = 4;
   localparam int RandomItems   = 40;
   localparam int StoreSize     = SlotsDef * LineLenDef;

   // Status word fields, lowest bit last
   typedef struct packed {
      logic [CountW-1:0] pending_lines;
      logic [ByteW-1:0]  read_data;
      logic              overflow;
      logic [LSlotW-1:0] line_slot;
      logic              line_ready;
   } line_status_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_THIRD,
      READY_MOSTLY
   } stall_mode_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   // rx_byte [7:0], read_slot [9:8], read_offset [17:10], zero [23:18]
   logic [ReqDataW-1:0] req_tdata  = '0;
   // command [1:0]
   logic [CmdW-1:0]     req_tuser  = CMD_PUSH;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // line_ready [0], line_slot [2:1], overflow [3], read_data [11:4],
   // pending_lines [19:12], zero [23:20]
   logic [RspDataW-1:0] rsp_tdata;

   uart_line_ring_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Line buffer mirror
   logic [ByteW-1:0]  line_copy [StoreSize];
   bit                byte_written [StoreSize];
   int                written_addrs[$];
   int                put_slot   = 0;
   int                put_offset = 0;
   int                take_slot  = 0;
   logic [CountW-1:0] lines_waiting = '0;
   logic              lines_lost    = 1'b0;
   line_status_type   status_due[$];

   int errors = 0;
   int n_items = 0, n_push = 0, n_newline = 0, n_get = 0, n_done = 0, n_read = 0;
   int n_status = 0;
   int burst_left = 0;
   bit hold_toggle = 1'b0;

   function automatic int ring_next(input int s);
      return (s >= SlotsDef - 1) ? 0 : s + 1;
   endfunction

   // Apply one command to the mirror and return the status word it yields
   function automatic line_status_type buffer_status(input cmd_type cmd, input logic [7:0] rx,
                                                     input logic [1:0] rslot,
                                                     input logic [7:0] roff);
      line_status_type st;
      int addr;
      st = '0;
      case (cmd)
         CMD_PUSH: begin
            addr = put_slot * LineLenDef + put_offset;
            line_copy[addr] = rx;
            if (!byte_written[addr]) begin
               byte_written[addr] = 1'b1;
               written_addrs.push_back(addr);
            end
            if (rx == NEWLINE) begin
               put_slot   = ring_next(put_slot);
               put_offset = 0;
               if (lines_waiting != COUNT_MAX) lines_waiting++;
            end else if (put_offset < LineLenDef - 1) begin
               put_offset++;
            end
            if (lines_waiting > SlotsDef) lines_lost = 1'b1;
         end
         CMD_GET: begin
            if (lines_waiting != 0) begin
               st.line_ready = 1'b1;
               st.line_slot  = LSlotW'(take_slot);
               take_slot     = ring_next(take_slot);
            end
         end
         CMD_DONE: begin
            if (lines_waiting != 0) lines_waiting--;
         end
         default: begin
            if (int'(rslot) < SlotsDef && int'(roff) < LineLenDef)
               st.read_data = line_copy[int'(rslot) * LineLenDef + int'(roff)];
         end
      endcase
      st.overflow      = lines_lost;
      st.pending_lines = lines_waiting;
      return st;
   endfunction

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (b == NEWLINE);
      return b;
   endfunction

   function automatic int any_written();
      return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
   endfunction

   // Offer one word in bursts with random gaps; record its status once taken
   task automatic send_word(input cmd_type cmd, input logic [7:0] rx,
                            input logic [1:0] rslot, input logic [7:0] roff);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(ReqDataW - ByteW - RSlotW - ROffW){1'b0}}, roff, rslot, rx};
      do @(posedge clock); while (!req_tready);
      status_due.push_back(buffer_status(cmd, rx, rslot, roff));
      n_items++;
      case (cmd)
         CMD_PUSH: begin
            n_push++;
            if (rx == NEWLINE) n_newline++;
         end
         CMD_GET:  n_get++;
         CMD_DONE: n_done++;
         default:  n_read++;
      endcase
   endtask

   task automatic send_push(input logic [7:0] b);
      send_word(CMD_PUSH, b, 2'($urandom), 8'($urandom));
   endtask

   task automatic send_ctrl(input cmd_type cmd);
      send_word(cmd, 8'($urandom), 2'($urandom), 8'($urandom));
   endtask

   task automatic send_read(input int addr);
      send_word(CMD_READ, 8'($urandom), 2'(addr / LineLenDef), 8'(addr % LineLenDef));
   endtask

   // Stop offering and wait for every outstanding status word
   task automatic drain_status();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (status_due.size() != 0);
   endtask

   // Empty get and complete, short lines, reads, get keeps the count
   task automatic test_directed();
      send_ctrl(CMD_GET);
      send_ctrl(CMD_DONE);
      send_push(8'h00);
      send_push(8'hFF);
      send_push(8'h5A);
      send_push(NEWLINE);
      send_read(0);
      send_read(1);
      send_read(2);
      send_read(3);
      send_push(8'hA5);
      send_push(NEWLINE);
      // empty line: newline alone
      send_push(NEWLINE);
      send_ctrl(CMD_GET);
      send_ctrl(CMD_GET);
      send_read(LineLenDef + 1);
      send_ctrl(CMD_DONE);
      send_ctrl(CMD_DONE);
      send_ctrl(CMD_DONE);
      // complete with nothing pending
      send_ctrl(CMD_DONE);
      send_ctrl(CMD_GET);
   endtask

   // Line longer than a slot: offset sticks at the last byte
   task automatic test_long_line();
      int base;
      base = put_slot * LineLenDef;
      repeat (LineLenDef + 2) send_push(text_byte());
      send_push(NEWLINE);
      send_read(base + LineLenDef - 1);
      send_read(base + LineLenDef - 2);
      send_read(base + LineLenDef / 2);
      send_read(base);
      send_ctrl(CMD_GET);
      send_ctrl(CMD_DONE);
   endtask

   // Mostly whole lines and get/read/complete rounds, some noise
   task automatic test_random();
      int start, len, slot, addr, reads;
      cmd_type cmd;
      start = n_items;
      while (n_items - start < RandomItems) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
               repeat (len) send_push(text_byte());
               send_push(NEWLINE);
            end
            4, 5, 6: begin
               if (lines_waiting == 0) begin
                  send_ctrl(CMD_GET);
               end else begin
                  slot = take_slot;
                  send_ctrl(CMD_GET);
                  reads = $urandom_range(0, 4);
                  repeat (reads) begin
                     addr = slot * LineLenDef + $urandom_range(0, 15);
                     send_read(byte_written[addr] ? addr : any_written());
                  end
                  if ($urandom_range(0, 3) != 0) send_ctrl(CMD_DONE);
               end
            end
            default: begin
               cmd = cmd_type'($urandom_range(0, 3));
               if (cmd == CMD_READ) send_read(any_written());
               else if (cmd == CMD_PUSH) send_push(8'($urandom));
               else send_ctrl(cmd);
            end
         endcase
      end
      drain_status();
   endtask

   // Receiver holds off while words keep coming, then a full pause
   task automatic test_backpressure();
      hold_toggle = ~hold_toggle;
      repeat (30) begin
         if ($urandom_range(0, 1) == 0) send_push(8'($urandom));
         else send_read(any_written());
      end
      drain_status();
      repeat (10) send_read(any_written());
   endtask

   // Count saturates high with newlines, then steps back with completes
   task automatic test_count_limits();
      repeat (int'(COUNT_MAX) - int'(lines_waiting) + 3) send_push(NEWLINE);
      repeat (3) send_ctrl(CMD_GET);
      send_read(any_written());
      repeat (3) send_ctrl(CMD_DONE);
      send_ctrl(CMD_GET);
      send_push(8'h41);
   endtask

   // Result side: own stall pattern plus long hold-offs on request
   stall_mode_type stall_mode = READY_ALWAYS;
   int  mode_left = 0;
   int  hold_left = 0;
   bit  hold_seen = 1'b0;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(16, 80);
      end
      mode_left--;
      if (hold_seen != hold_toggle) begin
         hold_seen = hold_toggle;
         hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
            READY_THIRD:  rsp_tready <= (mode_left % 3 == 0);
            default:      rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // Compare each status word with the oldest prediction
   always @(posedge clock) begin
      line_status_type seen, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_status++;
         seen = rsp_tdata[$bits(line_status_type)-1:0];
         if (status_due.size() == 0) begin
            $error("status word %h with no command outstanding", rsp_tdata);
            errors++;
         end else begin
            want = status_due.pop_front();
            check_field("line_ready", want.line_ready, seen.line_ready);
            check_field("line_slot", want.line_slot, seen.line_slot);
            check_field("overflow", want.overflow, seen.overflow);
            check_field("read_data", want.read_data, seen.read_data);
            check_field("pending_lines", want.pending_lines, seen.pending_lines);
            check_field("pad", 8'd0, rsp_tdata[RspDataW-1:$bits(line_status_type)]);
         end
      end
   end

   // Watchdog on cycles with no word moving on either side
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog: no word moved for %0d cycles", idle_cycles);
         $display("tb_uart_line_ring_buffer: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_line();
      test_random();
      test_backpressure();
      test_count_limits();
      drain_status();
      repeat (DrainCycles) @(posedge clock);
      $display("%0d commands: %0d pushes (%0d newlines), %0d gets, %0d completes, %0d reads",
               n_items, n_push, n_newline, n_get, n_done, n_read);
      $display("%0d status words checked; clipped long line, count limits, overflow, stalls",
               n_status);
      if (errors == 0 && status_due.size() == 0) begin
         $display("tb_uart_line_ring_buffer: PASS");
      end else begin
         $display("tb_uart_line_ring_buffer: FAIL");
      end
      $finish;
   end

endmodule
